[rtl/palfade_pkg.sv]
// shared types, codes and constants of the palette fade sequencer
package palfade_pkg;

    // default palette depth
    localparam int PALETTE_ENTRIES_DEF = 32;

    // field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 5;
    localparam int VAL_W      = 8;
    localparam int TIME_W     = 16;
    localparam int STEP_W     = 5;
    localparam int DIR_W      = 2;
    localparam int SWP_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // most entries ever emitted by one fade step
    localparam int EMIT_MAX = 32;

    // input operation codes
    localparam logic [OP_W-1:0] OP_WRITE_WORK = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_TARG = 2'd1;
    localparam logic [OP_W-1:0] OP_START      = 2'd2;
    localparam logic [OP_W-1:0] OP_TIME       = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_HOOK   = 2'd1;

    // fade direction codes
    localparam logic [DIR_W-1:0] DIR_NONE    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DARKEN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LIGHTEN = 2'd2;

    // per-entry sweep operation codes
    localparam logic [SWP_W-1:0] SWP_NONE    = 2'd0;
    localparam logic [SWP_W-1:0] SWP_DARKEN  = 2'd1;
    localparam logic [SWP_W-1:0] SWP_LIGHTEN = 2'd2;
    localparam logic [SWP_W-1:0] SWP_COPY    = 2'd3;

    // result kinds
    localparam logic KIND_ENTRY    = 1'b0;
    localparam logic KIND_MIDPOINT = 1'b1;

    // fade steps with special meaning
    localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_MIDPOINT = 5'd8;
    localparam logic [STEP_W-1:0] STEP_LIGHTEN  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_END      = 5'd16;

    // colour constants
    localparam logic [VAL_W-1:0] LUMA_STEP   = 8'h10;
    localparam logic [VAL_W-1:0] LUMA_LIMIT  = 8'h40;
    localparam logic [VAL_W-1:0] BLACK_CODE  = 8'h0f;
    localparam logic [VAL_W-1:0] HUE_MASK    = 8'h0f;
    localparam logic [VAL_W-1:0] ALPHA_CODE  = 8'hff;

    // reset value of the step delay register
    localparam logic [TIME_W-1:0] DELAY_RESET = 16'd30;

    // commands from controller to datapath
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             rd_last;
        logic [SWP_W-1:0] swp_op;
        logic             mid_load;
        logic             we_work;
        logic             we_targ;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic b_valid;
        logic b_advance;
        logic out_free;
    } sts_t;

endpackage

[rtl/palette_fade_sequencer.sv]
// top level of the palette fade sequencer
//
//  channel  handshake              payload
//  in       in_valid / in_ready    op, entry_index, entry_value, time_units
//  out      out_valid / out_ready  kind, out_index, out_value, last
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// write and start words leave in_ready high; a time word that changes nothing
// goes through evaluate only; one that fades sweeps min(PALETTE_ENTRIES, 32)
// entries via the palette ram read port, one per cycle unless the output stalls.
// the midpoint adds a copy sweep of the same length after its event word.
// reset is asynchronous active low; palette contents stay undefined until written.
// an output stall holds a fade sweep at its current entry; in_ready drops while a
// time word is being worked on, and the next word is taken with a result still
// waiting in the output register.
module palette_fade_sequencer #(
    parameter int PALETTE_ENTRIES = palfade_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [palfade_pkg::OP_W-1:0]         op,
    input  logic [palfade_pkg::IDX_W-1:0]        entry_index,
    input  logic [palfade_pkg::VAL_W-1:0]        entry_value,
    input  logic [palfade_pkg::TIME_W-1:0]       time_units,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 kind,
    output logic [palfade_pkg::IDX_W-1:0]        out_index,
    output logic [palfade_pkg::VAL_W-1:0]        out_value,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [palfade_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [palfade_pkg::CFG_DATA_W-1:0]   cfg_data
);

    palfade_pkg::cmd_t cmd;
    palfade_pkg::sts_t sts;

    // controller
    palfade_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .entry_index (entry_index),
        .time_units  (time_units),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    // datapath
    palfade_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .out_index   (out_index),
        .out_value   (out_value),
        .last        (last)
    );

endmodule

[rtl/palfade_ram.sv]
// generic single write port, single read port ram with registered read
module palfade_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, holds while not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/palfade_ctrl.sv]
// fade controller: step, direction, time counter, config and sweep sequencing
module palfade_ctrl #(
    parameter int PALETTE_ENTRIES = palfade_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [palfade_pkg::OP_W-1:0]         op,
    input  logic [palfade_pkg::IDX_W-1:0]        entry_index,
    input  logic [palfade_pkg::TIME_W-1:0]       time_units,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [palfade_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [palfade_pkg::CFG_DATA_W-1:0]   cfg_data,
    output palfade_pkg::cmd_t                    cmd,
    input  palfade_pkg::sts_t                    sts
);

    localparam int EMIT_COUNT = (PALETTE_ENTRIES < palfade_pkg::EMIT_MAX) ?
                                PALETTE_ENTRIES : palfade_pkg::EMIT_MAX;
    localparam logic [palfade_pkg::IDX_W-1:0] LAST_IDX =
        palfade_pkg::IDX_W'(EMIT_COUNT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MID   = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [palfade_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [palfade_pkg::DIR_W-1:0]       dir_reg, dir_next;
    logic [palfade_pkg::TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic [palfade_pkg::TIME_W-1:0]      delay_reg, delay_next;
    logic                                hook_reg, hook_next;
    logic [palfade_pkg::IDX_W-1:0]       cnt_reg, cnt_next;
    logic [palfade_pkg::SWP_W-1:0]       swp_reg, swp_next;
    logic [palfade_pkg::TIME_W:0]        time_sum;
    logic                                in_acc;
    logic                                idx_ok;
    logic                                can_issue;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign idx_ok    = (int'(entry_index) < PALETTE_ENTRIES);
    assign time_sum  = {1'b0, elapsed_reg} + {1'b0, time_units};
    assign can_issue = !sts.b_valid || sts.b_advance;

    // configuration registers
    always_comb
    begin
        delay_next = delay_reg;
        hook_next  = hook_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == palfade_pkg::REG_STEP_DELAY)
            begin
                delay_next = cfg_data;
            end
            else if (cfg_index == palfade_pkg::REG_MID_HOOK)
            begin
                hook_next = cfg_data[0];
            end
        end
    end

    // fade sequencing
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        dir_next     = dir_reg;
        elapsed_next = elapsed_reg;
        cnt_next     = cnt_reg;
        swp_next     = swp_reg;
        cmd          = '0;
        cmd.rd_idx   = cnt_reg;
        cmd.rd_last  = (cnt_reg == LAST_IDX);
        cmd.swp_op   = swp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        palfade_pkg::OP_WRITE_WORK: cmd.we_work = idx_ok;
                        palfade_pkg::OP_WRITE_TARG: cmd.we_targ = idx_ok;
                        palfade_pkg::OP_START:
                        begin
                            step_next = palfade_pkg::STEP_FIRST;
                            dir_next  = palfade_pkg::DIR_DARKEN;
                        end
                        palfade_pkg::OP_TIME:
                        begin
                            elapsed_next = time_sum[palfade_pkg::TIME_W] ?
                                           '1 : time_sum[palfade_pkg::TIME_W-1:0];
                            state_next   = S_EVAL;
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (step_reg == '0 || step_reg >= palfade_pkg::STEP_END)
                begin
                    state_next = S_IDLE;
                end
                else if (step_reg[0])
                begin
                    elapsed_next = '0;
                    step_next    = step_reg + 1'b1;
                    cnt_next     = '0;
                    state_next   = S_SWEEP;
                    if (dir_reg == palfade_pkg::DIR_DARKEN)
                    begin
                        swp_next = palfade_pkg::SWP_DARKEN;
                    end
                    else if (dir_reg == palfade_pkg::DIR_LIGHTEN)
                    begin
                        swp_next = palfade_pkg::SWP_LIGHTEN;
                    end
                    else
                    begin
                        swp_next = palfade_pkg::SWP_NONE;
                    end
                end
                else if (elapsed_reg > delay_reg)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == palfade_pkg::STEP_MIDPOINT && hook_reg)
                    begin
                        dir_next   = palfade_pkg::DIR_NONE;
                        state_next = S_MID;
                    end
                    else if (step_reg == palfade_pkg::STEP_LIGHTEN)
                    begin
                        dir_next = palfade_pkg::DIR_LIGHTEN;
                    end
                end
            end
            S_SWEEP:
            begin
                if (can_issue)
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!sts.b_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MID:
            begin
                // midpoint word first, then copy target into working
                if (sts.out_free)
                begin
                    cmd.mid_load = 1'b1;
                    cnt_next     = '0;
                    swp_next     = palfade_pkg::SWP_COPY;
                    state_next   = S_SWEEP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            dir_reg     <= palfade_pkg::DIR_NONE;
            elapsed_reg <= '0;
            delay_reg   <= palfade_pkg::DELAY_RESET;
            hook_reg    <= 1'b0;
            cnt_reg     <= '0;
            swp_reg     <= palfade_pkg::SWP_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            dir_reg     <= dir_next;
            elapsed_reg <= elapsed_next;
            delay_reg   <= delay_next;
            hook_reg    <= hook_next;
            cnt_reg     <= cnt_next;
            swp_reg     <= swp_next;
        end
    end

endmodule

[rtl/palfade_datapath.sv]
// palette memories, per-entry colour update stage and result register
module palfade_datapath #(
    parameter int PALETTE_ENTRIES = palfade_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  palfade_pkg::cmd_t                 cmd,
    output palfade_pkg::sts_t                 sts,
    input  logic [palfade_pkg::IDX_W-1:0]     entry_index,
    input  logic [palfade_pkg::VAL_W-1:0]     entry_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [palfade_pkg::IDX_W-1:0]     out_index,
    output logic [palfade_pkg::VAL_W-1:0]     out_value,
    output logic                              last
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [palfade_pkg::VAL_W-1:0]  work_rdata;
    logic [palfade_pkg::VAL_W-1:0]  targ_rdata;
    logic                           work_we;
    logic [AW-1:0]                  work_waddr;
    logic [palfade_pkg::VAL_W-1:0]  work_wdata;

    logic                           b_valid_reg;
    logic [palfade_pkg::IDX_W-1:0]  b_idx_reg;
    logic                           b_last_reg;
    logic [palfade_pkg::SWP_W-1:0]  b_op_reg;

    logic                           out_valid_reg;
    logic                           kind_reg;
    logic [palfade_pkg::IDX_W-1:0]  out_index_reg;
    logic [palfade_pkg::VAL_W-1:0]  out_value_reg;
    logic                           last_reg;

    logic                           out_free;
    logic                           b_advance;
    logic                           b_emit;
    logic                           is_alpha;
    logic [palfade_pkg::VAL_W-1:0]  dark_val;
    logic [palfade_pkg::VAL_W-1:0]  light_val;
    logic [palfade_pkg::VAL_W-1:0]  new_val;

    // palette memories
    palfade_ram #(
        .WIDTH (palfade_pkg::VAL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (cmd.rd_en),
        .raddr (AW'(cmd.rd_idx)),
        .rdata (work_rdata)
    );

    palfade_ram #(
        .WIDTH (palfade_pkg::VAL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_targ_ram (
        .clk   (clk),
        .we    (cmd.we_targ),
        .waddr (AW'(entry_index)),
        .wdata (entry_value),
        .re    (cmd.rd_en),
        .raddr (AW'(cmd.rd_idx)),
        .rdata (targ_rdata)
    );

    // colour update of the entry in the read stage
    always_comb
    begin
        is_alpha = b_idx_reg[palfade_pkg::IDX_W-1] && (b_idx_reg[1:0] == 2'b00);
        dark_val = work_rdata - palfade_pkg::LUMA_STEP;
        if (dark_val >= palfade_pkg::LUMA_LIMIT)
        begin
            dark_val = palfade_pkg::BLACK_CODE;
        end
        light_val = work_rdata + palfade_pkg::LUMA_STEP;
        if (light_val >= targ_rdata)
        begin
            light_val = targ_rdata;
        end
        unique case (b_op_reg)
            palfade_pkg::SWP_DARKEN:  new_val = is_alpha ? palfade_pkg::ALPHA_CODE : dark_val;
            palfade_pkg::SWP_LIGHTEN: new_val = is_alpha ? palfade_pkg::ALPHA_CODE : light_val;
            palfade_pkg::SWP_COPY:    new_val = targ_rdata & palfade_pkg::HUE_MASK;
            default:                  new_val = work_rdata;
        endcase
    end

    // stage handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign b_emit    = (b_op_reg != palfade_pkg::SWP_COPY);
    assign b_advance = b_valid_reg && (!b_emit || out_free);

    assign sts.b_valid   = b_valid_reg;
    assign sts.b_advance = b_advance;
    assign sts.out_free  = out_free;

    // working palette write: sweep write-back or host write
    always_comb
    begin
        work_we    = cmd.we_work;
        work_waddr = AW'(entry_index);
        work_wdata = entry_value;
        if (b_advance)
        begin
            work_we    = 1'b1;
            work_waddr = AW'(b_idx_reg);
            work_wdata = new_val;
        end
    end

    // read stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (cmd.rd_en)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_advance)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            b_idx_reg  <= cmd.rd_idx;
            b_last_reg <= cmd.rd_last;
            b_op_reg   <= cmd.swp_op;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((b_advance && b_emit) || cmd.mid_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.mid_load)
        begin
            kind_reg      <= palfade_pkg::KIND_MIDPOINT;
            out_index_reg <= '0;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
        end
        else if (b_advance && b_emit)
        begin
            kind_reg      <= palfade_pkg::KIND_ENTRY;
            out_index_reg <= b_idx_reg;
            out_value_reg <= new_val;
            last_reg      <= b_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    // a new read never overwrites data still waiting in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (!b_valid_reg || b_advance))
        else $error("read issued over a held entry");

    // host writes only happen with the sweep stage empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.we_work || cmd.we_targ) |-> !b_valid_reg)
        else $error("host write during sweep");

    // midpoint word only loads into a free result register with no sweep pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mid_load |-> (out_free && !b_valid_reg && !cmd.rd_en))
        else $error("midpoint load collides");

    // an emitted entry appears at the result register on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_advance && b_emit) |=> (out_valid_reg && kind_reg == palfade_pkg::KIND_ENTRY))
        else $error("emitted entry lost");

endmodule
